// File: hw/rtl/twcbf_pkg.sv
// twcbf_pkg: sizes, codes, reset values and hash constants of the
// time window counting bloom filter; used by every file of the block but twcbf_ram
package twcbf_pkg;

    localparam int ROWS        = 8;
    localparam int MAX_CELLS   = 1024;
    localparam int BASE_WINDOW = 3;

    localparam int HASH_W  = 32;
    localparam int CELL_W  = 8;
    localparam int SEC_W   = 17;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int WIN_W   = $clog2(ROWS + 1);
    localparam int COLS_W  = $clog2(MAX_CELLS + 1);
    localparam int DEPTH   = ROWS * MAX_CELLS;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CNT_REG_W  = 11;
    localparam int AGE_REG_W  = 16;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_THRESH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT  = 2'd2;

    localparam logic [CNT_REG_W-1:0] RST_CELL_COUNT = 11'd1024;
    localparam logic [CNT_REG_W-1:0] RST_SAT_THRESH = 11'd819;
    localparam logic [AGE_REG_W-1:0] RST_AGE_LIMIT  = 16'd60;

    localparam logic [HASH_W-1:0] DJB2_INIT  = 32'd5381;
    localparam logic [HASH_W-1:0] SDBM_INIT  = 32'd0;
    localparam logic [HASH_W-1:0] FNV_INIT   = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME  = 32'd16777619;

    localparam logic [CELL_W-1:0] CELL_MAX    = 8'd255;
    localparam logic [SEC_W-1:0]  SECONDS_MAX = 17'd131071;

endpackage

// File: hw/rtl/twcbf_in_if.sv
// twcbf_in_if: input channel of the filter, one key byte or tick per item
// depends on twcbf_pkg
interface twcbf_in_if;
    import twcbf_pkg::*;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [7:0]       key_byte;
    logic             has_byte;
    logic             key_last;

    modport source (output valid, command, key_byte, has_byte, key_last, input ready);
    modport sink   (input valid, command, key_byte, has_byte, key_last, output ready);
endinterface

// File: hw/rtl/twcbf_out_if.sv
// twcbf_out_if: result channel of the filter, one item per finished operation
// depends on twcbf_pkg
interface twcbf_out_if;
    import twcbf_pkg::*;
    logic             valid;
    logic             ready;
    logic             status;
    logic             present;
    logic [WIN_W-1:0] active_rows;
    logic             expanded;

    modport source (output valid, status, present, active_rows, expanded, input ready);
    modport sink   (input valid, status, present, active_rows, expanded, output ready);
endinterface

// File: hw/rtl/twcbf_ram.sv
// twcbf_ram: generic single port ram with registered read
// no dependencies
module twcbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/twcbf_mod.sv
// twcbf_mod: bit serial remainder unit, one dividend bit per cycle
// depends on twcbf_pkg
module twcbf_mod (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [twcbf_pkg::HASH_W-1:0]   i_dividend,
    input  logic [twcbf_pkg::COLS_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic [twcbf_pkg::COLS_W-1:0]   o_rem
);
    import twcbf_pkg::*;

    localparam int STEP_W = $clog2(HASH_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [HASH_W-1:0] r_quo;
    logic [COLS_W-1:0] r_rem;
    logic [COLS_W-1:0] r_div;
    logic [COLS_W:0]   trial;
    logic              fits;

    assign trial = {r_rem, r_quo[HASH_W-1]};
    assign fits  = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo  <= {r_quo[HASH_W-2:0], 1'b0};
                r_rem  <= fits ? COLS_W'(trial - {1'b0, r_div}) : trial[COLS_W-1:0];
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(HASH_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// File: hw/rtl/time_window_counting_bloom_filter.sv
// time_window_counting_bloom_filter: top level of the sliding window counting
// bloom filter; depends on twcbf_pkg, twcbf_in_if, twcbf_out_if, twcbf_mod, twcbf_ram
// sequence: a key byte or tick item is taken while idle; a last item runs, for
//   each of three hashes, a column and a row remainder in the shared unit, a
//   cell read and an update, plus a sweep of MAX_CELLS cells for every row retired or added
// throughput: one item at a time, ready only while the sequencer is idle
// reset: synchronous active low; afterwards the whole cell store is swept to
//   zero, all ROWS x MAX_CELLS cells, during which no item is taken
module time_window_counting_bloom_filter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    twcbf_in_if.sink                       i_in,
    twcbf_out_if.source                    o_res,
    input  logic                           i_cfg_we,
    input  logic [twcbf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [twcbf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import twcbf_pkg::*;

    // sequencer codes
    localparam int ST_W = 4;
    localparam logic [ST_W-1:0] S_CLR  = 4'd0;  // memory sweep to zero
    localparam logic [ST_W-1:0] S_IDLE = 4'd1;  // taking items
    localparam logic [ST_W-1:0] S_AGE  = 4'd2;  // retire oldest row if due
    localparam logic [ST_W-1:0] S_HASH = 4'd3;  // start column remainder
    localparam logic [ST_W-1:0] S_MODC = 4'd4;  // wait column, start row remainder
    localparam logic [ST_W-1:0] S_MODR = 4'd5;  // wait row, form address
    localparam logic [ST_W-1:0] S_RD   = 4'd6;  // cell read in flight
    localparam logic [ST_W-1:0] S_UPD  = 4'd7;  // read-modify-write of the cell
    localparam logic [ST_W-1:0] S_NEXT = 4'd8;  // next hash or finish
    localparam logic [ST_W-1:0] S_FIN  = 4'd9;  // hand result to output register

    // configuration
    logic [CNT_REG_W-1:0] r_cell_count;
    logic [CNT_REG_W-1:0] r_sat_thresh;
    logic [AGE_REG_W-1:0] r_age_limit;

    // filter state
    logic [ST_W-1:0]   r_state;
    logic [ST_W-1:0]   r_ret;
    logic [CELL_W-1:0] r_occ [ROWS];
    logic [ROW_W-1:0]  r_oldest;
    logic [WIN_W-1:0]  r_window;
    logic              r_expanded;
    logic [SEC_W-1:0]  r_seconds;
    logic [HASH_W-1:0] r_acc_djb;
    logic [HASH_W-1:0] r_acc_sdbm;
    logic [HASH_W-1:0] r_acc_fnv;

    // operation in progress
    logic [HASH_W-1:0] r_h [3];
    logic [1:0]        r_idx;
    logic [CMD_W-1:0]  r_cmd;
    logic [COLS_W-1:0] r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [ADDR_W-1:0] r_clr_last;
    logic              r_present;
    logic              r_hit;

    // output register
    logic              r_out_valid;
    logic              r_out_status;
    logic              r_out_present;
    logic [WIN_W-1:0]  r_out_rows;
    logic              r_out_expanded;

    // hash fold of the incoming byte
    logic [HASH_W-1:0] byte_ext;
    logic [HASH_W-1:0] n_djb;
    logic [HASH_W-1:0] n_sdbm;
    logic [HASH_W-1:0] n_fnv;
    logic              in_acc;

    assign byte_ext = HASH_W'(i_in.key_byte);
    assign n_djb    = (r_acc_djb << 5) + r_acc_djb + byte_ext;
    assign n_sdbm   = byte_ext + (r_acc_sdbm << 6) + (r_acc_sdbm << 16) - r_acc_sdbm;
    assign n_fnv    = HASH_W'((r_acc_fnv ^ byte_ext) * FNV_PRIME);
    assign in_acc   = i_in.valid && i_in.ready;

    // column modulus: zero acts as one, clamp at the store width
    logic [COLS_W-1:0] cols;
    always_comb begin
        if (r_cell_count == '0) begin
            cols = COLS_W'(1);
        end else if (32'(r_cell_count) > 32'(MAX_CELLS)) begin
            cols = COLS_W'(MAX_CELLS);
        end else begin
            cols = COLS_W'(r_cell_count);
        end
    end

    // shared remainder unit
    logic              div_start;
    logic              div_done;
    logic [COLS_W-1:0] div_rem;
    logic [COLS_W-1:0] div_divisor;

    assign div_start   = (r_state == S_HASH) || (r_state == S_MODC && div_done);
    assign div_divisor = (r_state == S_HASH) ? cols : COLS_W'(r_window);

    twcbf_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_h[r_idx]),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // ring arithmetic, sums stay below twice ROWS
    logic [ROW_W:0]   row_sum;
    logic [ROW_W-1:0] row_pick;
    logic [ROW_W:0]   wide_sum;
    logic [ROW_W-1:0] wide_row;
    logic [ROW_W:0]   next_sum;
    logic [ROW_W-1:0] next_oldest;

    assign row_sum     = (ROW_W + 1)'(r_oldest) + div_rem[ROW_W:0];
    assign row_pick    = (row_sum >= (ROW_W + 1)'(ROWS)) ?
                         ROW_W'(row_sum - (ROW_W + 1)'(ROWS)) : row_sum[ROW_W-1:0];
    assign wide_sum    = (ROW_W + 1)'(r_oldest) + (ROW_W + 1)'(r_window);
    assign wide_row    = (wide_sum >= (ROW_W + 1)'(ROWS)) ?
                         ROW_W'(wide_sum - (ROW_W + 1)'(ROWS)) : wide_sum[ROW_W-1:0];
    assign next_sum    = (ROW_W + 1)'(r_oldest) + (ROW_W + 1)'(1);
    assign next_oldest = (next_sum >= (ROW_W + 1)'(ROWS)) ? '0 : next_sum[ROW_W-1:0];

    // cell store
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [CELL_W-1:0] ram_wdata;
    logic [CELL_W-1:0] cell_q;
    logic [CELL_W-1:0] occ;
    logic [CELL_W-1:0] n_occ;
    logic [CELL_W-1:0] n_cell;
    logic              cell_wr;
    logic              do_widen;

    assign occ = r_occ[r_row];

    // cell update by command
    always_comb begin
        n_occ   = occ;
        n_cell  = cell_q;
        cell_wr = 1'b0;
        case (r_cmd)
            CMD_INSERT: begin
                if (cell_q == '0 && occ < CELL_MAX) begin
                    n_occ = occ + 1'b1;
                end
                if (cell_q < CELL_MAX) begin
                    n_cell = cell_q + 1'b1;
                end
                cell_wr = 1'b1;
            end
            CMD_REMOVE: begin
                if (cell_q != '0) begin
                    n_cell  = cell_q - 1'b1;
                    cell_wr = 1'b1;
                    if (cell_q == CELL_W'(1) && occ != '0) begin
                        n_occ = occ - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // widening on an insert once occupancy passes the threshold, only while not yet expanded and room is left
    assign do_widen = (r_cmd == CMD_INSERT) && !r_expanded
                      && (CNT_REG_W'(n_occ) > r_sat_thresh)
                      && (32'(r_window) < 32'(ROWS));

    assign ram_we    = (r_state == S_CLR) || (r_state == S_UPD && cell_wr);
    assign ram_addr  = (r_state == S_CLR) ? r_clr_addr : r_addr;
    assign ram_wdata = (r_state == S_CLR) ? '0 : n_cell;

    twcbf_ram #(
        .WIDTH (CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (cell_q)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count <= RST_CELL_COUNT;
            r_sat_thresh <= RST_SAT_THRESH;
            r_age_limit  <= RST_AGE_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CELL_COUNT: r_cell_count <= i_cfg_data[CNT_REG_W-1:0];
                CFG_SAT_THRESH: r_sat_thresh <= i_cfg_data[CNT_REG_W-1:0];
                CFG_AGE_LIMIT:  r_age_limit  <= i_cfg_data[AGE_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_ret       <= S_IDLE;
            r_clr_addr  <= '0;
            r_clr_last  <= ADDR_W'(DEPTH - 1);
            for (int i = 0; i < ROWS; i++) begin
                r_occ[i] <= '0;
            end
            r_oldest    <= '0;
            r_window    <= WIN_W'((ROWS < BASE_WINDOW) ? ROWS : BASE_WINDOW);
            r_expanded  <= 1'b0;
            r_seconds   <= '0;
            r_acc_djb   <= DJB2_INIT;
            r_acc_sdbm  <= SDBM_INIT;
            r_acc_fnv   <= FNV_INIT;
            r_out_valid <= 1'b0;
        end else begin
            // the finish state loads the output register itself
            if (o_res.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == r_clr_last) begin
                        r_state <= r_ret;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.command == CMD_TICK) begin
                            if (r_seconds < SECONDS_MAX) begin
                                r_seconds <= r_seconds + 1'b1;
                            end
                        end else if (i_in.key_last) begin
                            r_h[0]     <= i_in.has_byte ? n_djb  : r_acc_djb;
                            r_h[1]     <= i_in.has_byte ? n_sdbm : r_acc_sdbm;
                            r_h[2]     <= i_in.has_byte ? n_fnv  : r_acc_fnv;
                            r_acc_djb  <= DJB2_INIT;
                            r_acc_sdbm <= SDBM_INIT;
                            r_acc_fnv  <= FNV_INIT;
                            r_cmd      <= i_in.command;
                            r_state    <= S_AGE;
                        end else if (i_in.has_byte) begin
                            r_acc_djb  <= n_djb;
                            r_acc_sdbm <= n_sdbm;
                            r_acc_fnv  <= n_fnv;
                        end
                    end
                end
                S_AGE: begin
                    r_idx     <= '0;
                    r_present <= 1'b1;
                    r_hit     <= 1'b0;
                    if (r_seconds > SEC_W'(r_age_limit)) begin
                        // retire: clear the oldest row, slide, maybe shrink
                        r_occ[r_oldest] <= '0;
                        r_oldest        <= next_oldest;
                        r_seconds       <= '0;
                        if (r_expanded && r_window > WIN_W'(1)) begin
                            r_window <= r_window - 1'b1;
                            if (r_window - 1'b1 <= WIN_W'(BASE_WINDOW)) begin
                                r_expanded <= 1'b0;
                            end
                        end
                        r_clr_addr <= ADDR_W'(r_oldest) * ADDR_W'(MAX_CELLS);
                        r_clr_last <= ADDR_W'(r_oldest) * ADDR_W'(MAX_CELLS)
                                      + ADDR_W'(MAX_CELLS - 1);
                        r_ret      <= S_HASH;
                        r_state    <= S_CLR;
                    end else begin
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    r_state <= S_MODC;
                end
                S_MODC: begin
                    if (div_done) begin
                        r_col   <= div_rem;
                        r_state <= S_MODR;
                    end
                end
                S_MODR: begin
                    if (div_done) begin
                        r_row   <= row_pick;
                        r_addr  <= ADDR_W'(row_pick) * ADDR_W'(MAX_CELLS) + ADDR_W'(r_col);
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_occ[r_row] <= n_occ;
                    if (cell_q == '0) begin
                        r_present <= 1'b0;
                    end else begin
                        r_hit <= 1'b1;
                    end
                    if (do_widen) begin
                        // take in the row just past the window, cleared
                        r_occ[wide_row] <= '0;
                        r_window        <= r_window + 1'b1;
                        r_expanded      <= 1'b1;
                        r_seconds       <= '0;
                        r_clr_addr      <= ADDR_W'(wide_row) * ADDR_W'(MAX_CELLS);
                        r_clr_last      <= ADDR_W'(wide_row) * ADDR_W'(MAX_CELLS)
                                           + ADDR_W'(MAX_CELLS - 1);
                        r_ret           <= S_NEXT;
                        r_state         <= S_CLR;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (r_idx == 2'd2) begin
                        r_state <= S_FIN;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_HASH;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid    <= 1'b1;
                        r_out_status   <= (r_cmd == CMD_REMOVE) && !r_hit;
                        r_out_present  <= (r_cmd == CMD_QUERY) && r_present;
                        r_out_rows     <= r_window;
                        r_out_expanded <= r_expanded;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.status      = r_out_status;
    assign o_res.present     = r_out_present;
    assign o_res.active_rows = r_out_rows;
    assign o_res.expanded    = r_out_expanded;

    // an expanded window is always wider than the base window
    a_expanded_wide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_expanded |-> (r_window > WIN_W'(BASE_WINDOW)))
        else $error("expanded flag with narrow window");

    // window never empty and never beyond the ring
    a_window_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_window != '0) && (32'(r_window) <= 32'(ROWS)))
        else $error("window size out of range");

    // a finished operation with a free output register shows its result next cycle
    a_fin_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && !r_out_valid) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not delivered");

    // the remainder unit is only started from the hash sequencing states
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (r_state == S_HASH || r_state == S_MODC))
        else $error("remainder unit started out of sequence");
endmodule

// File: tb/testbench.sv
// testbench: self-checking bench for time_window_counting_bloom_filter
// depends on twcbf_pkg, twcbf_in_if, twcbf_out_if and the filter rtl
`timescale 1ns / 100ps

module testbench;
    import twcbf_pkg::*;

    typedef struct packed {
        logic             status;
        logic             present;
        logic [WIN_W-1:0] active_rows;
        logic             expanded;
    } t_filter_result;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    twcbf_in_if  in_if ();
    twcbf_out_if res_if ();

    time_window_counting_bloom_filter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if.sink),
        .o_res      (res_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // shadow copy of the filter state
    logic [CELL_W-1:0] shadow_cells [DEPTH];
    logic [CELL_W-1:0] shadow_occ [ROWS];
    int unsigned       shadow_oldest;
    int unsigned       shadow_window;
    logic              shadow_expanded;
    int unsigned       shadow_seconds;
    logic [HASH_W-1:0] djb_acc, sdbm_acc, fnv_acc;
    int unsigned       reg_cells, reg_thresh, reg_age;

    t_filter_result expected_results [$];
    int  fail_count;
    int  burst_left;
    int  hold_left;
    bit  hold_request;
    int  ready_pct;

    // key pool so queries and removes often hit inserted keys
    logic [7:0] key_pool [16][8];
    int         key_len [16];

    function automatic int unsigned active_columns();
        if (reg_cells == 0) return 1;
        if (reg_cells > MAX_CELLS) return MAX_CELLS;
        return reg_cells;
    endfunction

    function automatic void clear_shadow_row(int unsigned r);
        for (int c = 0; c < MAX_CELLS; c++) shadow_cells[r*MAX_CELLS + c] = '0;
        shadow_occ[r] = '0;
    endfunction

    function automatic void reset_hashes();
        djb_acc  = DJB2_INIT;
        sdbm_acc = SDBM_INIT;
        fnv_acc  = FNV_INIT;
    endfunction

    function automatic void shadow_reset();
        for (int r = 0; r < ROWS; r++) clear_shadow_row(r);
        shadow_oldest   = 0;
        shadow_window   = (ROWS < BASE_WINDOW) ? ROWS : BASE_WINDOW;
        shadow_expanded = 1'b0;
        shadow_seconds  = 0;
        reset_hashes();
        reg_cells  = RST_CELL_COUNT;
        reg_thresh = RST_SAT_THRESH;
        reg_age    = RST_AGE_LIMIT;
    endfunction

    // cell address of one hash, row returned through r
    function automatic int unsigned cell_addr(logic [HASH_W-1:0] h, output int unsigned r);
        int unsigned w;
        w = (shadow_window == 0) ? 1 : shadow_window;
        r = (shadow_oldest + h % w) % ROWS;
        return r * MAX_CELLS + h % active_columns();
    endfunction

    function automatic void widen_shadow();
        if (shadow_window >= ROWS) return;
        clear_shadow_row((shadow_oldest + shadow_window) % ROWS);
        shadow_window++;
        shadow_expanded = 1'b1;
        shadow_seconds  = 0;
    endfunction

    function automatic void retire_shadow();
        logic shrink;
        shrink = shadow_expanded && shadow_window > 1;
        clear_shadow_row(shadow_oldest);
        shadow_oldest  = (shadow_oldest + 1) % ROWS;
        shadow_seconds = 0;
        if (shrink) begin
            shadow_window--;
            if (shadow_window <= BASE_WINDOW) shadow_expanded = 1'b0;
        end
    endfunction

    // applies one accepted item to the shadow state, queues any result
    function automatic void filter_predict(logic [CMD_W-1:0] cmd, logic [7:0] kb,
                                           logic has, logic last);
        logic [HASH_W-1:0] h [3];
        t_filter_result    res;
        int unsigned       r, k;
        logic              hit;
        if (cmd == CMD_TICK) begin
            if (shadow_seconds < SECONDS_MAX) shadow_seconds++;
            return;
        end
        if (has) begin
            djb_acc  = (djb_acc << 5) + djb_acc + kb;
            sdbm_acc = kb + (sdbm_acc << 6) + (sdbm_acc << 16) - sdbm_acc;
            fnv_acc  = (fnv_acc ^ kb) * FNV_PRIME;
        end
        if (!last) return;
        h[0] = djb_acc;
        h[1] = sdbm_acc;
        h[2] = fnv_acc;
        reset_hashes();
        if (shadow_seconds > reg_age) retire_shadow();
        res = '0;
        case (cmd)
            CMD_INSERT: begin
                for (int i = 0; i < 3; i++) begin
                    k = cell_addr(h[i], r);
                    if (shadow_cells[k] == 0 && shadow_occ[r] < CELL_MAX) shadow_occ[r]++;
                    if (shadow_cells[k] < CELL_MAX) shadow_cells[k]++;
                    if (shadow_occ[r] > reg_thresh && !shadow_expanded) widen_shadow();
                end
            end
            CMD_QUERY: begin
                res.present = 1'b1;
                for (int i = 0; i < 3; i++) begin
                    k = cell_addr(h[i], r);
                    if (shadow_cells[k] == 0) begin
                        res.present = 1'b0;
                        break;
                    end
                end
            end
            default: begin
                hit = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    k = cell_addr(h[i], r);
                    if (shadow_cells[k] > 0) begin
                        hit = 1'b1;
                        shadow_cells[k]--;
                        if (shadow_cells[k] == 0 && shadow_occ[r] > 0) shadow_occ[r]--;
                    end
                end
                res.status = !hit;
            end
        endcase
        res.active_rows = WIN_W'(shadow_window);
        res.expanded    = shadow_expanded;
        expected_results.push_back(res);
    endfunction

    // handshakes are sampled at the falling edge, where everything is settled;
    // an item valid and ready there is taken at the next rising edge
    always @(negedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            filter_predict(in_if.command, in_if.key_byte, in_if.has_byte, in_if.key_last);
    end

    always @(negedge i_clk) begin
        t_filter_result got, want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = '{res_if.status, res_if.present, res_if.active_rows, res_if.expanded};
            if (expected_results.size() == 0) begin
                $display("%0t: result with none expected: %p", $time, got);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
                    fail_count++;
                end
                if (got.present !== want.present) begin
                    $display("%0t: present expected %0d actual %0d", $time,
                             want.present, got.present);
                    fail_count++;
                end
                if (got.active_rows !== want.active_rows) begin
                    $display("%0t: active_rows expected %0d actual %0d", $time,
                             want.active_rows, got.active_rows);
                    fail_count++;
                end
                if (got.expanded !== want.expanded) begin
                    $display("%0t: expanded expected %0d actual %0d", $time,
                             want.expanded, got.expanded);
                    fail_count++;
                end
            end
        end
    end

    // receiver: random stall pattern, with a long hold counted down here
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_left    <= 3000;
            hold_request = 1'b0;
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) < ready_pct);
        end
    end

    // stall density moves between none, light and heavy
    always begin
        repeat (300) @(posedge i_clk);
        case ($urandom_range(0, 2))
            0: ready_pct = 100;
            1: ready_pct = 70;
            default: ready_pct = 25;
        endcase
    end

    // drives one item, in bursts with random gaps, and waits until it is taken
    task automatic send_item(logic [CMD_W-1:0] cmd, logic [7:0] kb, logic has, logic last);
        logic rdy;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                in_if.valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
        burst_left--;
        in_if.valid    <= 1'b1;
        in_if.command  <= cmd;
        in_if.key_byte <= kb;
        in_if.has_byte <= has;
        in_if.key_last <= last;
        do begin
            @(negedge i_clk);
            rdy = in_if.ready;
            @(posedge i_clk);
        end while (!rdy);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (expected_results.size() != 0) @(posedge i_clk);
        // a trailing tick or an unfinished clear may still be in flight
        repeat (2 * MAX_CELLS + 300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_CELL_COUNT) reg_cells = val & 16'h7FF;
        else if (idx == CFG_SAT_THRESH) reg_thresh = val & 16'h7FF;
        else if (idx == CFG_AGE_LIMIT) reg_age = val;
    endtask

    task automatic set_regs(int unsigned cells, int unsigned thresh, int unsigned age);
        wait_drained();
        write_reg(CFG_CELL_COUNT, CFG_DATA_W'(cells));
        write_reg(CFG_SAT_THRESH, CFG_DATA_W'(thresh));
        write_reg(CFG_AGE_LIMIT, CFG_DATA_W'(age));
    endtask

    // whole key from the pool, final command given, with a random tick now and then
    task automatic send_pool_key(int idx, logic [CMD_W-1:0] cmd);
        int n;
        n = key_len[idx];
        if (n == 0) begin
            send_item(cmd, 8'($urandom), 1'b0, 1'b1);
            return;
        end
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
            send_item(i == n - 1 ? cmd : CMD_W'($urandom_range(0, 2)),
                      key_pool[idx][i], 1'b1, i == n - 1);
        end
    endtask

    task automatic fill_key_pool();
        for (int k = 0; k < 16; k++) begin
            key_len[k] = (k == 0) ? 0 : $urandom_range(1, 6);
            for (int i = 0; i < 8; i++) key_pool[k][i] = 8'($urandom);
        end
        key_len[1] = 1;
        key_pool[1][0] = 8'h00;
        key_len[2] = 1;
        key_pool[2][0] = 8'hFF;
    endtask

    // empty keys, byte extremes, every command, removes on absent cells
    task automatic test_directed();
        send_item(CMD_QUERY, 8'h00, 1'b0, 1'b1);
        send_item(CMD_REMOVE, 8'hFF, 1'b0, 1'b1);
        send_item(CMD_INSERT, 8'h00, 1'b0, 1'b1);
        send_item(CMD_QUERY, 8'h00, 1'b0, 1'b1);
        send_item(CMD_REMOVE, 8'h00, 1'b0, 1'b1);
        send_item(CMD_REMOVE, 8'h00, 1'b0, 1'b1);
        send_pool_key(1, CMD_INSERT);
        send_pool_key(2, CMD_INSERT);
        send_pool_key(2, CMD_QUERY);
        send_pool_key(1, CMD_QUERY);
        // non-last item without a byte, and a command that is ignored mid-key
        send_item(CMD_REMOVE, 8'h55, 1'b0, 1'b0);
        send_item(CMD_QUERY, 8'hAA, 1'b1, 1'b0);
        send_item(CMD_TICK, 8'hFF, 1'b1, 1'b1);
        send_item(CMD_QUERY, 8'h5A, 1'b1, 1'b1);
        send_pool_key(3, CMD_REMOVE);
    endtask

    // low threshold widens at once; ticks past a small limit retire and shrink
    task automatic test_window_ageing();
        set_regs(16, 0, 1);
        for (int i = 0; i < 4; i++) send_pool_key(3 + i, CMD_INSERT);
        for (int i = 0; i < 3; i++) begin
            send_item(CMD_TICK, 8'h00, 1'b0, 1'b0);
            send_item(CMD_TICK, 8'hFF, 1'b1, 1'b1);
            send_pool_key(3 + i, CMD_QUERY);
            send_pool_key(4 + i, CMD_REMOVE);
        end
    endtask

    task automatic random_items(int count);
        int sent;
        sent = 0;
        while (sent < count) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_item(CMD_TICK, 8'($urandom), 1'($urandom), 1'($urandom));
                    sent++;
                end
                1: begin
                    // noise: lone random item
                    send_item(CMD_W'($urandom_range(0, 2)), 8'($urandom), 1'($urandom),
                              1'($urandom));
                    sent++;
                end
                default: begin
                    int idx;
                    idx = $urandom_range(0, 15);
                    send_pool_key(idx, CMD_W'($urandom_range(0, 2)));
                    sent += (key_len[idx] == 0) ? 1 : key_len[idx];
                end
            endcase
            if ($urandom_range(0, 40) == 0) fill_key_pool();
        end
    endtask

    // long receiver hold while items keep coming, then a full drain
    task automatic test_back_pressure();
        hold_request = 1'b1;
        random_items(60);
        wait_drained();
    endtask

    task automatic test_random_settings();
        set_regs(1, 0, 0);
        random_items(250);
        set_regs(MAX_CELLS, 1024, 65535);
        random_items(250);
        set_regs(0, 2, 2);
        random_items(250);
        set_regs(2047, 2047, 1);
        random_items(250);
        set_regs(37, 5, 3);
        random_items(250);
        set_regs(RST_CELL_COUNT, RST_SAT_THRESH, RST_AGE_LIMIT);
        random_items(150);
    endtask

    initial begin
        fail_count   = 0;
        burst_left   = 0;
        hold_left    = 0;
        hold_request = 1'b0;
        ready_pct    = 100;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        in_if.valid    <= 1'b0;
        in_if.command  <= CMD_INSERT;
        in_if.key_byte <= '0;
        in_if.has_byte <= 1'b0;
        in_if.key_last <= 1'b0;
        shadow_reset();
        fill_key_pool();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_window_ageing();
        test_back_pressure();
        test_random_settings();

        wait_drained();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // allows the reset sweep and the slowest legal run several times over
    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: time_window_counting_bloom_filter.f
hw/rtl/twcbf_pkg.sv
hw/rtl/twcbf_in_if.sv
hw/rtl/twcbf_out_if.sv
hw/rtl/twcbf_ram.sv
hw/rtl/twcbf_mod.sv
hw/rtl/time_window_counting_bloom_filter.sv
tb/testbench.sv
